/* design/vpf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpf_pkg
// Shared types, constants and saturation helpers of the vintage pixel filter.
// ----------------------------------------------------------------------------
package vpf_pkg;

  // channel order: blue, green, red
  localparam int Channels   = 3;
  localparam int ChanBlue   = 0;
  localparam int ChanGreen  = 1;
  localparam int ChanRed    = 2;

  // gamma table geometry
  localparam int TableEntries = 256;
  localparam int TableAw      = $clog2(TableEntries);
  localparam int PixW         = 8;
  localparam int NoiseW       = 9;

  // input beat layout
  localparam int InDataW    = 72;
  localparam int InNoiseLsb = Channels * PixW;
  localparam int InIdxLsb   = InNoiseLsb + Channels * NoiseW;
  localparam int InValLsb   = InIdxLsb + TableAw;
  localparam int OutDataW   = Channels * PixW;

  // configuration port
  localparam int CfgIdxW  = 8;
  localparam int CfgDataW = 8;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN   = 8'd0,
    CFG_OFFSET = 8'd1,
    CFG_GRAIN  = 8'd2,
    CFG_YELLOW = 8'd3
  } cfg_idx_e;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_TABLE = 1'b1
  } cmd_e;

  // register reset values
  localparam logic [7:0] GainReset   = 8'd60;
  localparam logic [7:0] OffsetReset = 8'hF6;  // -10
  localparam logic [7:0] GrainReset  = 8'd50;
  localparam logic [7:0] YellowReset = 8'd20;

  // bias keeps the corrected value positive before the divide by 100
  localparam logic [17:0] CorrBias   = 18'd20000;
  localparam logic [9:0]  BiasQuot   = 10'd200;
  // floor(w / 100) = (w * RecipHundred) >> 24 for w < 2^17
  localparam logic [17:0] RecipHundred = 18'd167773;
  localparam int          RecipHundredSh = 24;
  // floor(t / 3) = (t * RecipThree) >> 11 for t < 2^11
  localparam logic [9:0]  RecipThree = 10'd683;
  // floor(3x / 20) = (x * RecipTint) >> 16
  localparam logic [13:0] RecipTint  = 14'd9831;
  // floor(3x / 10) = (x * RecipRed) >> 16
  localparam logic [14:0] RecipRed   = 15'd19661;
  localparam logic [7:0]  BlueDrop   = 8'd5;

  typedef logic [PixW-1:0] pix_t;

  // clamp an 11-bit signed value to 0..255
  function automatic pix_t sat_s11(input logic signed [10:0] v);
    pix_t res;
    if (v[10]) begin
      res = '0;
    end else if (v[9:8] != 2'b00) begin
      res = '1;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

  // clamp an unsigned 10-bit value to 0..255
  function automatic pix_t sat_u10(input logic [9:0] v);
    pix_t res;
    if (v[9:8] != 2'b00) begin
      res = '1;
    end else begin
      res = v[7:0];
    end
    return res;
  endfunction

endpackage

/* design/vintage_pixel_filter.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vintage_pixel_filter
// Per-pixel gain/offset, gamma lookup, film grain and yellow tint.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries commands. tuser = cmd: a pixel beat produces one output
//   beat, a table beat writes one gamma entry and produces nothing.
//   m_axis returns the filtered pixel. The cfg channel writes the four
//   registers (gain, offset, grain depth, yellow depth) and is always ready;
//   write it only while no pixel is in flight.
//   Load all gamma entries before sending pixels.
// Timing:
//   six-stage pipeline (scale, divide, gamma read, grain, mean, tint), one
//   beat per cycle sustained while m_axis accepts. The gamma table sits in
//   three copies of a 256x8 RAM (one read port per channel); table writes
//   take the same pipeline path as reads, so they stay ordered.
// Reset:
//   clears the pipeline valid bits and loads the register defaults; the
//   gamma RAM is not cleared.
// Stall:
//   each stage moves whenever the stage after it is empty or moving, so
//   bubbles collapse; s_axis_tready_o drops only when all stages are full
//   and m_axis_tready_i is low.
// ----------------------------------------------------------------------------
module vintage_pixel_filter
  import vpf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // input beats
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // tdata: pixel_blue, pixel_green, pixel_red, noise_blue, noise_green,
  //        noise_red, table_index, table_value, zero pad
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // tuser: cmd
  input  logic                s_axis_tuser_i,
  // result beats
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // tdata: out_blue, out_green, out_red
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // register writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // configuration registers
  logic [7:0] gain_q, offset_q, grain_q, yellow_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q   <= GainReset;
      offset_q <= OffsetReset;
      grain_q  <= GrainReset;
      yellow_q <= YellowReset;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_GAIN:   gain_q   <= cfg_data_i;
        CFG_OFFSET: offset_q <= cfg_data_i;
        CFG_GRAIN:  grain_q  <= cfg_data_i;
        CFG_YELLOW: yellow_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage valids and load enables
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic ld1, ld2, ld3, ld4, ld5, ld6;

  assign ld6 = !v6_q || m_axis_tready_i;
  assign ld5 = !v5_q || ld6;
  assign ld4 = !v4_q || ld5;
  assign ld3 = !v3_q || ld4;
  assign ld2 = !v2_q || ld3;
  assign ld1 = !v1_q || ld2;

  assign s_axis_tready_o = ld1;

  // stage payload registers
  logic                              cmd1_q, cmd2_q;
  logic [Channels-1:0][16:0]         w1_q, w2_q;
  logic [Channels-1:0][9:0]          q2_q;
  logic [Channels-1:0][NoiseW-1:0]   n1_q, n2_q, n3_q;
  logic [TableAw-1:0]                tidx1_q, tidx2_q;
  pix_t                              tval1_q, tval2_q;
  logic [Channels-1:0][PixW-1:0]     px4_q, px5_q, px6_q;
  logic [7:0]                        s5_q;

  // stage 1 input: scaled value plus bias, always positive
  logic signed [17:0]           bias;
  logic [Channels-1:0][16:0]    w_in;
  logic [Channels-1:0][15:0]    prod_in;

  always_comb begin
    bias = $signed(CorrBias) + 18'(signed'(offset_q)) * 18'sd100;
    for (int c = 0; c < Channels; c++) begin
      prod_in[c] = 16'(s_axis_tdata_i[c*PixW +: PixW]) * 16'(gain_q);
      w_in[c]    = {1'b0, prod_in[c]} + bias[16:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      cmd1_q  <= s_axis_tuser_i;
      w1_q    <= w_in;
      for (int c = 0; c < Channels; c++) begin
        n1_q[c] <= s_axis_tdata_i[InNoiseLsb + c*NoiseW +: NoiseW];
      end
      tidx1_q <= s_axis_tdata_i[InIdxLsb +: TableAw];
      tval1_q <= s_axis_tdata_i[InValLsb +: PixW];
    end
  end

  // stage 2: quotient by 100 through a reciprocal multiply
  logic [Channels-1:0][34:0] qprod;

  always_comb begin
    for (int c = 0; c < Channels; c++) begin
      qprod[c] = 35'(w1_q[c]) * 35'(RecipHundred);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld2) begin
      cmd2_q  <= cmd1_q;
      w2_q    <= w1_q;
      for (int c = 0; c < Channels; c++) begin
        q2_q[c] <= qprod[c][RecipHundredSh +: 10];
      end
      n2_q    <= n1_q;
      tidx2_q <= tidx1_q;
      tval2_q <= tval1_q;
    end
  end

  // stage 3: round half to even, remove bias, saturate, gamma lookup
  logic [Channels-1:0][16:0]        rem_full;
  logic [Channels-1:0][6:0]         rem;
  logic [Channels-1:0]              rnd;
  logic [Channels-1:0][11:0]        qs;
  logic [Channels-1:0][TableAw-1:0] raddr;
  logic [Channels-1:0][PixW-1:0]    gam;
  logic                             ram_we;

  always_comb begin
    for (int c = 0; c < Channels; c++) begin
      rem_full[c] = w2_q[c] - 17'(q2_q[c]) * 17'd100;
      rem[c]      = rem_full[c][6:0];
      rnd[c]      = (rem[c] > 7'd50) || ((rem[c] == 7'd50) && q2_q[c][0]);
      qs[c]       = {2'b00, q2_q[c]} + {11'b0, rnd[c]} - {2'b00, BiasQuot};
      if (qs[c][11]) begin
        raddr[c] = '0;
      end else if (qs[c][10:8] != 3'b000) begin
        raddr[c] = '1;
      end else begin
        raddr[c] = qs[c][7:0];
      end
    end
  end

  // a table write is committed as it leaves stage 2
  assign ram_we = v2_q && (cmd_e'(cmd2_q) == CMD_TABLE) && ld3;

  for (genvar gc = 0; gc < Channels; gc++) begin : g_gamma
    vpf_ram #(
      .Width(PixW),
      .Depth(TableEntries)
    ) u_gamma_ram (
      .clk_i  (clk_i),
      .we_i   (ram_we),
      .waddr_i(tidx2_q),
      .wdata_i(tval2_q),
      .re_i   (ld3),
      .raddr_i(raddr[gc]),
      .rdata_o(gam[gc])
    );
  end

  always_ff @(posedge clk_i) begin
    if (ld3) begin
      n3_q <= n2_q;
    end
  end

  // stage 4: grain
  logic signed [9:0]              depth;
  logic [Channels-1:0][9:0]       nc;
  logic signed [9:0]              half_g;
  logic signed [10:0]             sum_b, sum_g;
  logic signed [11:0]             t_r;
  logic [20:0]                    tprod;
  logic [Channels-1:0][PixW-1:0]  grain_px;

  always_comb begin
    depth = $signed({2'b00, grain_q});
    for (int c = 0; c < Channels; c++) begin
      nc[c] = 10'(signed'(n3_q[c]));
      if ($signed(nc[c]) > depth) begin
        nc[c] = depth;
      end else if ($signed(nc[c]) < -depth) begin
        nc[c] = -depth;
      end
    end
    // blue takes the whole sample
    sum_b = $signed({3'b000, gam[ChanBlue]}) + $signed({nc[ChanBlue][9], nc[ChanBlue]});
    grain_px[ChanBlue] = sat_s11(sum_b);
    // green takes half, truncated toward zero
    half_g = ($signed(nc[ChanGreen]) + $signed({9'b0, nc[ChanGreen][9]})) >>> 1;
    sum_g  = $signed({3'b000, gam[ChanGreen]}) + $signed({half_g[9], half_g});
    grain_px[ChanGreen] = sat_s11(sum_g);
    // red: floor((3y + 2n) / 3)
    t_r = $signed({4'b0000, gam[ChanRed]}) + $signed({3'b000, gam[ChanRed], 1'b0})
        + $signed({nc[ChanRed][9], nc[ChanRed], 1'b0});
    tprod = 21'(t_r[10:0]) * 21'(RecipThree);
    if (t_r[11]) begin
      grain_px[ChanRed] = '0;
    end else begin
      grain_px[ChanRed] = sat_u10(tprod[20:11]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld4) begin
      px4_q <= grain_px;
    end
  end

  // stage 5: channel mean
  logic [9:0]  csum;
  logic [19:0] sprod;

  always_comb begin
    csum  = 10'(px4_q[ChanBlue]) + 10'(px4_q[ChanGreen]) + 10'(px4_q[ChanRed]);
    sprod = 20'(csum) * 20'(RecipThree);
  end

  always_ff @(posedge clk_i) begin
    if (ld5) begin
      px5_q <= px4_q;
      s5_q  <= sprod[18:11];
    end
  end

  // stage 6: yellow tint into the output register
  logic [8:0]                    tint_x;
  logic [22:0]                   gprod, rprod;
  logic [Channels-1:0][PixW-1:0] tint_px;

  always_comb begin
    tint_x = 9'(s5_q) + 9'(yellow_q);
    gprod  = 23'(tint_x) * 23'(RecipTint);
    rprod  = 23'(s5_q) * 23'(RecipRed);
    if (px5_q[ChanBlue] < BlueDrop) begin
      tint_px[ChanBlue] = '0;
    end else begin
      tint_px[ChanBlue] = px5_q[ChanBlue] - BlueDrop;
    end
    tint_px[ChanGreen] = sat_u10(10'(px5_q[ChanGreen]) + 10'(gprod[22:16]));
    tint_px[ChanRed]   = sat_u10(10'(px5_q[ChanRed]) + 10'(rprod[22:16]));
  end

  always_ff @(posedge clk_i) begin
    if (ld6) begin
      px6_q <= tint_px;
    end
  end

  // valid bits; table beats drop out after the RAM write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (ld1) v1_q <= s_axis_tvalid_i;
      if (ld2) v2_q <= v1_q;
      if (ld3) v3_q <= v2_q && (cmd_e'(cmd2_q) == CMD_PIXEL);
      if (ld4) v4_q <= v3_q;
      if (ld5) v5_q <= v4_q;
      if (ld6) v6_q <= v5_q;
    end
  end

  assign m_axis_tvalid_o = v6_q;
  assign m_axis_tdata_o  = px6_q;

  // a table beat never turns into a result
  a_table_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> !v3_q)
    else $error("table write reached the lookup stage as a pixel");

  // input stalls only when every stage holds a pixel and the sink stalls
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (v1_q && v2_q && v3_q && v4_q && v5_q && v6_q &&
                          !m_axis_tready_i))
    else $error("input stalled with a bubble in the pipeline");

  // a held result keeps its data
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> $stable(px6_q))
    else $error("stalled result changed");

endmodule

/* design/vpf_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module vpf_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* verif/vpf_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpf_checker
// Watches the input, result and register channels of the vintage pixel
// filter. It keeps its own copy of the registers and the gamma table and
// predicts every filtered pixel. Each result beat is compared field by field
// with the oldest prediction.
// ----------------------------------------------------------------------------
module vpf_checker
  import vpf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // input channel
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  // tdata: pixel_blue, pixel_green, pixel_red, noise_blue, noise_green,
  //        noise_red, table_index, table_value, zero pad
  input  logic [InDataW-1:0]  s_tdata_i,
  // tuser: cmd
  input  logic                s_tuser_i,
  // result channel
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  // tdata: out_blue, out_green, out_red
  input  logic [OutDataW-1:0] m_tdata_i,
  // register writes
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int                  fail_cnt_o,
  output int                  pend_cnt_o
);

  localparam int MaxReports = 10;

  // register values after reset
  localparam logic [7:0] RstGain   = 8'd60;
  localparam logic [7:0] RstOffset = 8'hF6;
  localparam logic [7:0] RstGrain  = 8'd50;
  localparam logic [7:0] RstYellow = 8'd20;

  // keeps the corrected value nonnegative ahead of the divide
  localparam int CorrOffsetBias = 20000;
  localparam int CorrQuotBias   = 200;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  logic [7:0] gain_r;
  logic [7:0] offset_r;
  logic [7:0] grain_r;
  logic [7:0] yellow_r;
  logic [7:0] gamma_mem [TableEntries];

  rgb_t filtered_q [$];

  function automatic int clip8(input int v);
    int res;
    res = v;
    if (v < 0) res = 0;
    if (v > 255) res = 255;
    return res;
  endfunction

  // gain, offset, round half to even, saturate, then gamma lookup
  function automatic int gamma_level(input logic [7:0] x);
    int w;
    int q;
    int rem;
    w = int'(x) * int'(gain_r) + 100 * int'($signed(offset_r)) + CorrOffsetBias;
    q = w / 100;
    rem = w % 100;
    if (rem > 50 || (rem == 50 && (q % 2) == 1)) q = q + 1;
    q = clip8(q - CorrQuotBias);
    return int'(gamma_mem[q]);
  endfunction

  // noise sample limited to the grain depth
  function automatic int grain_limit(input logic [NoiseW-1:0] raw);
    int n;
    int d;
    n = $signed(raw);
    d = int'(grain_r);
    if (n > d) n = d;
    if (n < -d) n = -d;
    return n;
  endfunction

  function automatic rgb_t filter_pixel(input logic [InDataW-1:0] d);
    int b;
    int g;
    int r;
    int s;
    int t;
    int nb;
    int ng;
    int nr;
    rgb_t res;
    b = gamma_level(d[ChanBlue*PixW +: PixW]);
    g = gamma_level(d[ChanGreen*PixW +: PixW]);
    r = gamma_level(d[ChanRed*PixW +: PixW]);
    nb = grain_limit(d[InNoiseLsb + ChanBlue*NoiseW +: NoiseW]);
    ng = grain_limit(d[InNoiseLsb + ChanGreen*NoiseW +: NoiseW]);
    nr = grain_limit(d[InNoiseLsb + ChanRed*NoiseW +: NoiseW]);
    // film grain
    b = clip8(b + nb);
    g = clip8(g + ng / 2);
    t = 3 * r + 2 * nr;
    r = (t < 0) ? 0 : clip8(t / 3);
    // yellow tint
    s = (b + g + r) / 3;
    b = clip8(b - 5);
    g = clip8(g + (15 * (s + int'(yellow_r))) / 100);
    r = clip8(r + (3 * s) / 10);
    res.blue  = b[7:0];
    res.green = g[7:0];
    res.red   = r[7:0];
    return res;
  endfunction

  task automatic note_fail(input string msg);
    if (fail_cnt_o < MaxReports) $display("%0t: %s", $time, msg);
    fail_cnt_o++;
  endtask

  // sample all three channels at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    rgb_t want;
    rgb_t got;
    if (!rst_ni) begin
      gain_r     = RstGain;
      offset_r   = RstOffset;
      grain_r    = RstGrain;
      yellow_r   = RstYellow;
      fail_cnt_o = 0;
      pend_cnt_o = 0;
      filtered_q.delete();
    end else begin
      // register write beat
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_GAIN:   gain_r   = cfg_data_i;
          CFG_OFFSET: offset_r = cfg_data_i;
          CFG_GRAIN:  grain_r  = cfg_data_i;
          CFG_YELLOW: yellow_r = cfg_data_i;
          default: ;
        endcase
      end
      // result beat against the oldest prediction
      if (m_tvalid_i && m_tready_i) begin
        got.blue  = m_tdata_i[ChanBlue*PixW +: PixW];
        got.green = m_tdata_i[ChanGreen*PixW +: PixW];
        got.red   = m_tdata_i[ChanRed*PixW +: PixW];
        if (filtered_q.size() == 0) begin
          note_fail($sformatf("unexpected result beat b=%0d g=%0d r=%0d",
                              got.blue, got.green, got.red));
        end else begin
          want = filtered_q.pop_front();
          if (got.blue != want.blue || got.green != want.green || got.red != want.red) begin
            note_fail($sformatf("pixel mismatch: expected b=%0d g=%0d r=%0d, got b=%0d g=%0d r=%0d",
                                want.blue, want.green, want.red,
                                got.blue, got.green, got.red));
          end
        end
      end
      // input beat: table write or pixel
      if (s_tvalid_i && s_tready_i) begin
        if (s_tuser_i == CMD_TABLE) begin
          gamma_mem[s_tdata_i[InIdxLsb +: TableAw]] = s_tdata_i[InValLsb +: PixW];
        end else begin
          filtered_q.push_back(filter_pixel(s_tdata_i));
        end
      end
      pend_cnt_o = filtered_q.size();
    end
  end

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the vintage pixel filter. Loads the gamma table,
// runs directed extremes and rounding ties, then random pixel traffic with
// table rewrites under several register settings. Input beats come in
// bursts with random gaps while the result side stalls on its own pattern;
// vpf_checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import vpf_pkg::*;

  localparam int CycleLimit  = 500000;
  localparam int DrainCycles = 12;
  localparam int ItemsPerSet = 160;

  // indexes that map to no register
  localparam logic [CfgIdxW-1:0] CfgFirstFree = 8'd4;
  localparam logic [CfgIdxW-1:0] CfgIdxMax    = 8'hFF;

  // result side stall patterns
  localparam int RxOpen  = 0;
  localparam int RxCoin  = 1;
  localparam int RxComb  = 2;
  localparam int RxTight = 3;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                s_axis_tuser = CMD_PIXEL;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  int fail_cnt;
  int pend_cnt;
  int cycle_cnt = 0;
  int burst_left = 1;
  int grain_sel = 50;
  bit tx_up = 1'b0;
  int rx_mode = RxOpen;
  int rx_left = 0;
  int rx_tick = 0;

  always #5 clk_i = ~clk_i;

  vintage_pixel_filter u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  vpf_checker u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .fail_cnt_o  (fail_cnt),
    .pend_cnt_o  (pend_cnt)
  );

  // result side: switch between randomly chosen stall patterns
  always @(posedge clk_i) begin
    rx_tick <= rx_tick + 1;
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(RxOpen, RxTight);
      rx_left <= $urandom_range(16, 160);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      RxOpen:  m_axis_tready <= 1'b1;
      RxCoin:  m_axis_tready <= 1'($urandom_range(0, 1));
      RxComb:  m_axis_tready <= (rx_tick % 4 == 0);
      default: m_axis_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("vintage_pixel_filter test failed");
      $finish;
    end
  end

  function automatic logic [InDataW-1:0] pack_beat(
    input logic [PixW-1:0]   pb,
    input logic [PixW-1:0]   pg,
    input logic [PixW-1:0]   pr,
    input logic [NoiseW-1:0] nb,
    input logic [NoiseW-1:0] ng,
    input logic [NoiseW-1:0] nr,
    input logic [TableAw-1:0] idx,
    input logic [PixW-1:0]   val
  );
    logic [InDataW-1:0] d;
    d = '0;
    d[ChanBlue*PixW +: PixW]  = pb;
    d[ChanGreen*PixW +: PixW] = pg;
    d[ChanRed*PixW +: PixW]   = pr;
    d[InNoiseLsb + ChanBlue*NoiseW +: NoiseW]  = nb;
    d[InNoiseLsb + ChanGreen*NoiseW +: NoiseW] = ng;
    d[InNoiseLsb + ChanRed*NoiseW +: NoiseW]   = nr;
    d[InIdxLsb +: TableAw] = idx;
    d[InValLsb +: PixW]    = val;
    return d;
  endfunction

  function automatic logic [PixW-1:0] rand_pix();
    logic [PixW-1:0] v;
    case ($urandom_range(0, 7))
      0:       v = '0;
      1:       v = '1;
      default: v = PixW'($urandom_range(0, 255));
    endcase
    return v;
  endfunction

  // mostly inside the grain depth, with edges and full-span samples
  function automatic logic [NoiseW-1:0] rand_noise(input int depth);
    int v;
    case ($urandom_range(0, 5))
      0:       v = $urandom;
      1:       v = depth;
      2:       v = -depth;
      3:       v = 0;
      default: v = int'($urandom_range(0, 2 * depth)) - depth;
    endcase
    return v[NoiseW-1:0];
  endfunction

  // one input beat; ends a burst with a random gap
  task automatic send_beat(input cmd_e cmd, input logic [InDataW-1:0] data);
    int gap;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= data;
    s_axis_tvalid <= 1'b1;
    tx_up = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    burst_left--;
    if (burst_left <= 0) begin
      s_axis_tvalid <= 1'b0;
      tx_up = 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 16);
    end
  endtask

  task automatic send_pixel(input int pb, input int pg, input int pr,
                            input int nb, input int ng, input int nr);
    send_beat(CMD_PIXEL, pack_beat(PixW'(pb), PixW'(pg), PixW'(pr),
                                   NoiseW'(nb), NoiseW'(ng), NoiseW'(nr),
                                   TableAw'($urandom), PixW'($urandom)));
  endtask

  // pixel and noise fields of a table beat carry junk
  task automatic send_table(input int idx, input int val);
    send_beat(CMD_TABLE, pack_beat(rand_pix(), rand_pix(), rand_pix(),
                                   NoiseW'($urandom), NoiseW'($urandom),
                                   NoiseW'($urandom), TableAw'(idx), PixW'(val)));
  endtask

  task automatic stream_idle();
    if (tx_up) begin
      s_axis_tvalid <= 1'b0;
      tx_up = 1'b0;
    end
  endtask

  // every prediction answered, then room for table writes still in flight
  task automatic wait_idle();
    @(posedge clk_i);
    while (pend_cnt != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  // new register setting, plus writes to indexes that hold no register
  task automatic set_regs(input int gain, input int offset, input int grain,
                          input int yellow);
    stream_idle();
    wait_idle();
    cfg_write(CFG_GAIN, CfgDataW'(gain));
    cfg_write(CFG_OFFSET, CfgDataW'(offset));
    cfg_write(CFG_GRAIN, CfgDataW'(grain));
    cfg_write(CFG_YELLOW, CfgDataW'(yellow));
    cfg_write(CfgIdxMax, CfgDataW'($urandom_range(0, 255)));
    cfg_write(CfgIdxW'($urandom_range(CfgFirstFree, CfgIdxMax - 1)),
              CfgDataW'($urandom_range(0, 255)));
    cfg_valid <= 1'b0;
    grain_sel = grain & 255;
  endtask

  // mostly pixels, some gamma rewrites
  task automatic random_items(input int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_table($urandom_range(0, 255), $urandom_range(0, 255));
      end else begin
        send_beat(CMD_PIXEL, pack_beat(rand_pix(), rand_pix(), rand_pix(),
                                       rand_noise(grain_sel), rand_noise(grain_sel),
                                       rand_noise(grain_sel), TableAw'($urandom),
                                       PixW'($urandom)));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity gamma table before any pixel
    for (int i = 0; i < TableEntries; i++) send_table(i, i);

    // reset register values: channel extremes and noise limits
    send_pixel(0, 0, 0, 0, 0, 0);
    send_pixel(255, 255, 255, 0, 0, 0);
    send_pixel(255, 255, 255, 255, 255, 255);
    send_pixel(0, 0, 0, -256, -256, -256);
    send_pixel(128, 128, 128, 200, 200, 200);
    send_pixel(128, 128, 128, -200, -200, -200);
    send_pixel(100, 150, 200, 50, 50, 50);
    send_pixel(100, 150, 200, -51, -51, -51);
    send_pixel(60, 70, 80, -1, -1, -1);
    send_pixel(60, 70, 80, 1, 1, 1);
    send_pixel(255, 0, 128, 3, -3, 2);
    send_pixel(0, 255, 0, -2, 5, -1);

    // half gain: odd inputs land on ties that round to even
    set_regs(50, 0, 50, 20);
    send_pixel(1, 3, 5, 0, 0, 0);
    send_pixel(7, 9, 255, 0, 0, 0);
    send_table(7, 7);
    send_pixel(7, 11, 13, 0, 0, 0);

    // random traffic across register settings
    set_regs(100, 0, 50, 20);
    random_items(ItemsPerSet);
    set_regs(200, 100, 200, 200);
    random_items(ItemsPerSet);
    set_regs(0, -100, 0, 0);
    random_items(ItemsPerSet);
    set_regs(255, 127, 255, 255);
    random_items(ItemsPerSet);
    set_regs(137, -128, 255, 0);
    random_items(ItemsPerSet);
    repeat (2) begin
      set_regs($urandom_range(0, 255), $urandom_range(0, 255),
               $urandom_range(0, 255), $urandom_range(0, 255));
      random_items(ItemsPerSet);
    end

    stream_idle();
    wait_idle();
    if (fail_cnt == 0 && pend_cnt == 0) begin
      $display("vintage_pixel_filter test passed");
    end else begin
      $display("vintage_pixel_filter test failed");
    end
    $finish;
  end

endmodule
